FILE: hw/rtl/lca_pkg.sv
// Shared constants for the life cellular automaton block.
package lca_pkg;

  // Fixed field widths
  localparam int ROW_BITS     = 32;
  localparam int ROW_IDX_BITS = 5;
  localparam int DIM_BITS     = 6;
  localparam int GEN_BITS     = 16;

  // Configuration port
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_BOARD_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_BOARD_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_GENERATIONS  = 2'd2;

  localparam logic [DIM_BITS-1:0] RST_BOARD_WIDTH  = 6'd32;
  localparam logic [DIM_BITS-1:0] RST_BOARD_HEIGHT = 6'd32;
  localparam logic [GEN_BITS-1:0] RST_GENERATIONS  = 16'd1;

  // Default size limits
  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_HEIGHT = 32;

  // B3/S23 rule
  localparam logic [3:0] LIFE_BIRTH   = 4'd3;
  localparam logic [3:0] LIFE_SURVIVE = 4'd2;

endpackage

FILE: hw/rtl/lca_row_unit.sv
// Row update unit: next generation of one row from its two neighbour rows.
module lca_row_unit #(
  parameter int COLS = lca_pkg::DEF_MAX_WIDTH
) (
  input  logic [COLS-1:0] up_row,
  input  logic [COLS-1:0] cur_row,
  input  logic [COLS-1:0] dn_row,
  input  logic [COLS-1:0] col_mask,
  output logic [COLS-1:0] nxt_row
);

  logic [COLS-1:0] up_lo, up_hi, cur_lo, cur_hi, dn_lo, dn_hi;

  // bit j of *_lo holds column j-1, bit j of *_hi holds column j+1
  assign up_lo  = {up_row[COLS-2:0], 1'b0};
  assign up_hi  = {1'b0, up_row[COLS-1:1]};
  assign cur_lo = {cur_row[COLS-2:0], 1'b0};
  assign cur_hi = {1'b0, cur_row[COLS-1:1]};
  assign dn_lo  = {dn_row[COLS-2:0], 1'b0};
  assign dn_hi  = {1'b0, dn_row[COLS-1:1]};

  always_comb begin
    logic [3:0] cnt;
    cnt     = '0;
    nxt_row = '0;
    for (int j = 0; j < COLS; j++) begin
      cnt = 4'($countones({up_lo[j], up_row[j], up_hi[j], cur_lo[j], cur_hi[j],
                           dn_lo[j], dn_row[j], dn_hi[j]}));
      nxt_row[j] = col_mask[j] &
                   ((cnt == lca_pkg::LIFE_BIRTH) ||
                    ((cnt == lca_pkg::LIFE_SURVIVE) && cur_row[j]));
    end
  end

endmodule

FILE: hw/rtl/life_cellular_automaton.sv
// Life cellular automaton top level: board store, generation sequencer, output register.
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, in_row_cells                 | input beat
//   out     | out_valid, out_stall, out_cells, out_row,        | output beat
//           | out_last_row                                     |
//   cfg     | cfg_we, cfg_addr, cfg_wdata                      | write only
//
// Row beats are taken while the input is not stalled; every row but the one completing the board
// is only written to the store. The completing row starts the sequencer, which sweeps the
// board through the single row update unit and the board store (one read and one write
// port) once per generation, then reads each row from the store into the output register.
// Reset clears control state only; the board store is not cleared.
// A stalled output holds its row; input stays stalled until the board is emitted.
module life_cellular_automaton #(
  parameter int MAX_WIDTH  = lca_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lca_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lca_pkg::ROW_BITS-1:0]        in_row_cells,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lca_pkg::ROW_BITS-1:0]        out_cells,
  output logic [lca_pkg::ROW_IDX_BITS-1:0]    out_row,
  output logic                                out_last_row,
  input  logic                                cfg_we,
  input  logic [lca_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [lca_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int COLS = (MAX_WIDTH < lca_pkg::ROW_BITS) ? MAX_WIDTH : lca_pkg::ROW_BITS;
  localparam int ROWS = (MAX_HEIGHT < lca_pkg::ROW_BITS) ? MAX_HEIGHT : lca_pkg::ROW_BITS;
  localparam int AW   = $clog2(ROWS);
  localparam int DW   = lca_pkg::DIM_BITS;
  localparam int GW   = lca_pkg::GEN_BITS;

  localparam logic [1:0] ST_LOAD    = 2'd0;
  localparam logic [1:0] ST_CALC    = 2'd1;
  localparam logic [1:0] ST_EMIT_RD = 2'd2;
  localparam logic [1:0] ST_EMIT_WR = 2'd3;

  logic [DW-1:0]  cfg_w_r, cfg_h_r;
  logic [GW-1:0]  cfg_gens_r;
  logic [DW-1:0]  w_eff, h_eff;
  logic [COLS-1:0] col_mask;

  logic [1:0]     state_r, state_nxt;
  logic [DW-1:0]  rows_loaded_r, rows_loaded_nxt;
  logic [DW-1:0]  pos_r, pos_nxt;
  logic [GW-1:0]  gen_r, gen_nxt;
  logic [DW-1:0]  emit_r, emit_nxt;

  logic [COLS-1:0] up_r, cur_r, dn_row, nxt_row;

  logic           out_valid_r, out_valid_nxt;
  logic [lca_pkg::ROW_BITS-1:0]     out_cells_r;
  logic [lca_pkg::ROW_IDX_BITS-1:0] out_row_r;
  logic           out_last_r;

  logic [COLS-1:0] grid_mem [ROWS];
  logic [COLS-1:0] mem_rdata_r;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [COLS-1:0] mem_wdata;

  logic           in_acc, out_load;
  logic [DW-1:0]  load_idx;
  logic           load_done;
  logic [DW-1:0]  calc_row;

  // effective board size
  always_comb begin
    w_eff = cfg_w_r;
    if (w_eff == '0) w_eff = DW'(1);
    if (w_eff > DW'(COLS)) w_eff = DW'(COLS);
    h_eff = cfg_h_r;
    if (h_eff == '0) h_eff = DW'(1);
    if (h_eff > DW'(ROWS)) h_eff = DW'(ROWS);
    for (int j = 0; j < COLS; j++) col_mask[j] = (DW'(j) < w_eff);
  end

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign load_idx  = (rows_loaded_r < h_eff) ? rows_loaded_r : h_eff - DW'(1);
  assign load_done = ((load_idx + DW'(1)) == h_eff);
  assign calc_row  = pos_r - DW'(2);

  // row below the one being updated: fresh from the store, dead past the last row
  assign dn_row = ((pos_r != '0) && (pos_r <= h_eff)) ? (mem_rdata_r & col_mask) : '0;

  lca_row_unit #(
    .COLS (COLS)
  ) u_row_unit (
    .up_row   (up_r),
    .cur_row  (cur_r),
    .dn_row   (dn_row),
    .col_mask (col_mask),
    .nxt_row  (nxt_row)
  );

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = load_idx[AW-1:0];
    mem_wdata = in_row_cells[COLS-1:0] & col_mask;
    mem_re    = 1'b0;
    mem_raddr = emit_r[AW-1:0];
    if (in_acc) begin
      mem_we = 1'b1;
    end else if ((state_r == ST_CALC) && (pos_r >= DW'(2))) begin
      mem_we    = 1'b1;
      mem_waddr = calc_row[AW-1:0];
      mem_wdata = nxt_row;
    end
    if ((state_r == ST_CALC) && (pos_r < h_eff)) begin
      mem_re    = 1'b1;
      mem_raddr = pos_r[AW-1:0];
    end else if (state_r == ST_EMIT_RD) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= grid_mem[mem_raddr];
  end

  assign out_load = (state_r == ST_EMIT_WR) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    rows_loaded_nxt = rows_loaded_r;
    pos_nxt         = pos_r;
    gen_nxt         = gen_r;
    emit_nxt        = emit_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (load_done) begin
            rows_loaded_nxt = '0;
            pos_nxt         = '0;
            gen_nxt         = '0;
            emit_nxt        = '0;
            state_nxt       = (cfg_gens_r == '0) ? ST_EMIT_RD : ST_CALC;
          end else begin
            rows_loaded_nxt = load_idx + DW'(1);
          end
        end
      end
      ST_CALC: begin
        if (pos_r == (h_eff + DW'(1))) begin
          pos_nxt = '0;
          gen_nxt = gen_r + GW'(1);
          if (gen_nxt == cfg_gens_r) state_nxt = ST_EMIT_RD;
        end else begin
          pos_nxt = pos_r + DW'(1);
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_load) begin
          if ((emit_r + DW'(1)) == h_eff) begin
            state_nxt = ST_LOAD;
          end else begin
            emit_nxt  = emit_r + DW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_LOAD;
      rows_loaded_r <= '0;
      pos_r         <= '0;
      gen_r         <= '0;
      emit_r        <= '0;
      out_valid_r   <= 1'b0;
      cfg_w_r       <= lca_pkg::RST_BOARD_WIDTH;
      cfg_h_r       <= lca_pkg::RST_BOARD_HEIGHT;
      cfg_gens_r    <= lca_pkg::RST_GENERATIONS;
    end else begin
      state_r       <= state_nxt;
      rows_loaded_r <= rows_loaded_nxt;
      pos_r         <= pos_nxt;
      gen_r         <= gen_nxt;
      emit_r        <= emit_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          lca_pkg::CFG_BOARD_WIDTH:  cfg_w_r    <= cfg_wdata[DW-1:0];
          lca_pkg::CFG_BOARD_HEIGHT: cfg_h_r    <= cfg_wdata[DW-1:0];
          lca_pkg::CFG_GENERATIONS:  cfg_gens_r <= cfg_wdata[GW-1:0];
          default: ;
        endcase
      end
    end
  end

  // window and output payload
  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      up_r  <= cur_r;
      cur_r <= dn_row;
    end
    if (out_load) begin
      out_cells_r <= lca_pkg::ROW_BITS'(mem_rdata_r & col_mask);
      out_row_r   <= emit_r[lca_pkg::ROW_IDX_BITS-1:0];
      out_last_r  <= ((emit_r + DW'(1)) == h_eff);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cells    = out_cells_r;
  assign out_row      = out_row_r;
  assign out_last_row = out_last_r;

endmodule

FILE: tb/sv/life_cellular_automaton_test.sv
// Self-checking testbench for the life cellular automaton block.
`timescale 1ns / 100ps

module life_cellular_automaton_test;
  import lca_pkg::*;

  typedef enum logic [0:0] {DO_WRITE, DO_ROW} script_op_t;

  typedef struct packed {
    script_op_t               op;
    logic [CFG_ADDR_BITS-1:0] reg_idx;
    logic [CFG_DATA_BITS-1:0] value;
    logic [ROW_BITS-1:0]      cells;
    logic                     typed;
    logic [ROW_BITS-1:0]      want;
  } script_step_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]     cells;
    logic [ROW_IDX_BITS-1:0] row;
    logic                    last;
  } board_row_t;

  localparam int SCRIPT_LEN  = 34;
  localparam int RANDOM_ROWS = 160;
  localparam int CALM_AFTER  = 130;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [ROW_BITS-1:0]      in_row_cells;
  logic                     out_valid;
  logic                     out_stall;
  logic [ROW_BITS-1:0]      out_cells;
  logic [ROW_IDX_BITS-1:0]  out_row;
  logic                     out_last_row;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  // Shadow of the block: board, load position and registers
  logic [ROW_BITS-1:0] life_board [DEF_MAX_HEIGHT];
  int                  rows_held;
  logic [DIM_BITS-1:0] cols_cfg;
  logic [DIM_BITS-1:0] rows_cfg;
  logic [GEN_BITS-1:0] gens_cfg;

  board_row_t   expected_rows [$];
  board_row_t   fresh_rows [$];
  script_step_t script [SCRIPT_LEN];

  bit calm;
  int rows_in, boards, rows_out, faults, random_rows;

  life_cellular_automaton uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row_cells (in_row_cells),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cells    (out_cells),
    .out_row      (out_row),
    .out_last_row (out_last_row),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int board_rows();
    int h;
    h = rows_cfg;
    if (h == 0) h = 1;
    if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
    return h;
  endfunction

  // Store one row; on the row that fills the board, run the generations and
  // leave the emitted board in fresh_rows. Returns the number of rows emitted.
  function automatic int absorb_row(logic [ROW_BITS-1:0] cells);
    int                  w, h, idx, r, c, dr, dc, n;
    int unsigned         g;
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] grown [DEF_MAX_HEIGHT];
    bit                  settled;
    w = cols_cfg;
    if (w == 0) w = 1;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    h = board_rows();
    mask = {ROW_BITS{1'b1}} >> (ROW_BITS - w);
    idx = (rows_held < h) ? rows_held : h - 1;
    life_board[idx] = cells & mask;
    rows_held = idx + 1;
    fresh_rows.delete();
    if (rows_held < h) return 0;
    rows_held = 0;
    for (r = 0; r < h; r++) life_board[r] &= mask;
    for (g = 0; g < gens_cfg; g++) begin
      settled = 1'b1;
      for (r = 0; r < h; r++) begin
        grown[r] = '0;
        for (c = 0; c < w; c++) begin
          n = 0;
          for (dr = -1; dr <= 1; dr++)
            for (dc = -1; dc <= 1; dc++)
              if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < h &&
                  c + dc >= 0 && c + dc < w)
                n += life_board[r + dr][c + dc];
          grown[r][c] = (n == LIFE_BIRTH) || (n == LIFE_SURVIVE && life_board[r][c]);
        end
      end
      for (r = 0; r < h; r++) begin
        if (grown[r] !== life_board[r]) settled = 1'b0;
        life_board[r] = grown[r];
      end
      // a still board stays still, so the remaining generations change nothing
      if (settled) break;
    end
    for (r = 0; r < h; r++)
      fresh_rows.push_back('{life_board[r], r[ROW_IDX_BITS-1:0], r == h - 1});
    return h;
  endfunction

  // Registers change only with nothing outstanding
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    in_valid = 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      CFG_BOARD_WIDTH:  cols_cfg = value[DIM_BITS-1:0];
      CFG_BOARD_HEIGHT: rows_cfg = value[DIM_BITS-1:0];
      CFG_GENERATIONS:  gens_cfg = value[GEN_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one row beat and hold it until taken
  task automatic send_row(input logic [ROW_BITS-1:0] cells, input bit typed,
                          input logic [ROW_BITS-1:0] want, output bit done);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_row_cells = cells;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    done = (absorb_row(cells) != 0);
    rows_in++;
    if (done) boards++;
    if (typed) expected_rows.push_back('{want, '0, 1'b1});
    else foreach (fresh_rows[k]) expected_rows.push_back(fresh_rows[k]);
    @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    board_row_t due;
    if (rst_n && out_valid && !out_stall) begin
      rows_out++;
      if (expected_rows.size() == 0) begin
        $display("%0t ns: unexpected board row: cells %h row %0d last %b",
                 $time, out_cells, out_row, out_last_row);
        faults++;
      end else begin
        due = expected_rows.pop_front();
        if (out_cells !== due.cells || out_row !== due.row || out_last_row !== due.last) begin
          $display("%0t ns: board row mismatch: expected cells %h row %0d last %b",
                   $time, due.cells, due.row, due.last);
          $display("%0t ns:                     got      cells %h row %0d last %b",
                   $time, out_cells, out_row, out_last_row);
          faults++;
        end
      end
    end
  end

  initial begin
    int                  s, phase;
    int unsigned         k, hv, wv, gv, pick;
    bit                  done, cut;
    logic [ROW_BITS-1:0] cells;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_row_cells = '0;
    cfg_we       = 1'b0;
    cfg_addr     = CFG_BOARD_WIDTH;
    cfg_wdata    = '0;
    calm         = 1'b0;
    rows_in      = 0;
    boards       = 0;
    rows_out     = 0;
    faults       = 0;
    random_rows  = 0;
    rows_held    = 0;
    cols_cfg     = RST_BOARD_WIDTH;
    rows_cfg     = RST_BOARD_HEIGHT;
    gens_cfg     = RST_GENERATIONS;
    foreach (life_board[i]) life_board[i] = '0;

    script = '{
      // single-row boards on reset width and generations
      '{DO_WRITE, CFG_BOARD_HEIGHT, 16'h0001, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'hFFFFFFFF, 1'b1, 32'h7FFFFFFE},
      '{DO_ROW,   '0,               16'h0,    32'h00000000, 1'b1, 32'h00000000},
      // no generations: board comes back as loaded
      '{DO_WRITE, CFG_GENERATIONS,  16'h0000, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5},
      // zero width acts as one column
      '{DO_WRITE, CFG_BOARD_WIDTH,  16'h0000, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'hFFFFFFFF, 1'b1, 32'h00000001},
      // oversize width clips to the full row
      '{DO_WRITE, CFG_BOARD_WIDTH,  16'h003F, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h80000001, 1'b1, 32'h80000001},
      '{DO_WRITE, CFG_BOARD_WIDTH,  16'h0005, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'hFFFFFFFF, 1'b1, 32'h0000001F},
      // zero height in the low bits acts as one row
      '{DO_WRITE, CFG_BOARD_HEIGHT, 16'hFFC0, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h0000002C, 1'b1, 32'h0000000C},
      // longest run: a lone row always dies out
      '{DO_WRITE, CFG_GENERATIONS,  16'hFFFF, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h0000001B, 1'b1, 32'h00000000},
      // blinker
      '{DO_WRITE, CFG_GENERATIONS,  16'h0001, 32'h0,        1'b0, 32'h0},
      '{DO_WRITE, CFG_BOARD_WIDTH,  16'h0020, 32'h0,        1'b0, 32'h0},
      '{DO_WRITE, CFG_BOARD_HEIGHT, 16'h0003, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000000, 1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h0000000E, 1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000000, 1'b0, 32'h0},
      // height dropped below the rows already loaded
      '{DO_WRITE, CFG_BOARD_HEIGHT, 16'h0006, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000001, 1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000002, 1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000003, 1'b0, 32'h0},
      '{DO_WRITE, CFG_BOARD_HEIGHT, 16'h0002, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h0000000F, 1'b0, 32'h0},
      // glider hitting the edges of a small board
      '{DO_WRITE, CFG_BOARD_WIDTH,  16'h0004, 32'h0,        1'b0, 32'h0},
      '{DO_WRITE, CFG_BOARD_HEIGHT, 16'h0004, 32'h0,        1'b0, 32'h0},
      '{DO_WRITE, CFG_GENERATIONS,  16'h0002, 32'h0,        1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000002, 1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000004, 1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000007, 1'b0, 32'h0},
      '{DO_ROW,   '0,               16'h0,    32'h00000000, 1'b0, 32'h0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (s = 0; s < SCRIPT_LEN; s++) begin
      if (script[s].op == DO_WRITE) write_reg(script[s].reg_idx, script[s].value);
      else send_row(script[s].cells, script[s].typed, script[s].want, done);
    end

    // Random boards: one whole board per pass, settings changed at random between boards
    phase = 0;
    while (random_rows < RANDOM_ROWS) begin
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) wv = 0;
        else if (pick == 1) wv = $urandom_range(33, 63);
        else if (pick == 2) wv = 32;
        else if (pick == 3) wv = 1;
        else wv = $urandom_range(2, 31);
        write_reg(CFG_BOARD_WIDTH, (16'($urandom) & 16'hFFC0) | 16'(wv));
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 9);
        if (phase == 0) hv = 33;
        else if (pick < 6) hv = $urandom_range(1, 8);
        else if (pick < 8) hv = $urandom_range(9, 31);
        else if (pick == 8) hv = $urandom_range(0, 1) ? 0 : 32;
        else hv = $urandom_range(33, 63);
        write_reg(CFG_BOARD_HEIGHT, 16'(hv));
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0 && board_rows() <= 2) gv = $urandom_range(100, 3000);
        else if (pick < 4) gv = $urandom_range(5, 24);
        else gv = $urandom_range(0, 4);
        write_reg(CFG_GENERATIONS, 16'(gv));
      end

      // now and then cut the height part way through the load
      cut = (board_rows() > 1 && $urandom_range(0, 5) == 0);
      k = cut ? $urandom_range(1, board_rows() - 1) : 0;
      done = 1'b0;
      while (!done) begin
        calm = (random_rows >= CALM_AFTER);
        if (cut && rows_held == k) begin
          write_reg(CFG_BOARD_HEIGHT, 16'($urandom_range(1, k)));
          cut = 1'b0;
        end
        case ($urandom_range(0, 6))
          0:       cells = $urandom & $urandom;
          1:       cells = $urandom | $urandom;
          2:       cells = '1;
          3:       cells = '0;
          4:       cells = 32'h7 << $urandom_range(0, 29);
          default: cells = $urandom;
        endcase
        send_row(cells, 1'b0, '0, done);
        random_rows++;
      end
      phase++;
    end

    calm     = 1'b1;
    in_valid = 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("Loaded %0d rows into %0d boards; %0d emitted rows compared.",
             rows_in, boards, rows_out);
    $display("Boards ranged from a single cell to 32 by 32, up to 65535 generations.");
    if (faults == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/lca_pkg.sv
hw/rtl/lca_row_unit.sv
hw/rtl/life_cellular_automaton.sv
tb/sv/life_cellular_automaton_test.sv
